FILE: src/sorted_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion shorthands; they expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SPQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted priority queue check failed");

// Next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted priority queue check failed");

`endif

FILE: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int DEPTH_DEF   = 16;
	localparam int DATA_W      = 32;
	localparam int PRIO_W      = 32;
	localparam int COUNT_OUT_W = 5;

	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_PEEK  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// One stored entry
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// Broadcast control from the top level to every cell
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t new_entry;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/spq_if.sv
// ----------------------------------------------------------------------------
// Sorted priority queue channel interfaces
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_req_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       req_type;
	logic signed [spq_pkg::DATA_W-1:0] new_data;
	logic signed [spq_pkg::PRIO_W-1:0] new_priority;

	modport source (output valid, output req_type, output new_data, output new_priority,
		input ready);
	modport sink (input valid, input req_type, input new_data, input new_priority,
		output ready);
endinterface

interface spq_res_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [spq_pkg::DATA_W-1:0]     out_data;
	logic signed [spq_pkg::PRIO_W-1:0]     out_priority;
	logic [1:0]                            status;
	logic [spq_pkg::COUNT_OUT_W-1:0]       count;
	logic                                  empty_res;

	modport source (output valid, output out_data, output out_priority, output status,
		output count, output empty_res, input ready);
	modport sink (input valid, input out_data, input out_priority, input status,
		input count, input empty_res, output ready);
endinterface

`default_nettype wire

FILE: src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, decides locally whether to
// keep it, take the new entry or take a neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF,
	parameter int INDEX = 0
) (
	input  wire logic                         clk,
	input  wire spq_pkg::cell_ctrl_t          ctrl,
	input  wire logic [$clog2(DEPTH+1)-1:0]   count,
	input  wire spq_pkg::entry_t              left_entry,
	input  wire logic                         left_keep,
	input  wire spq_pkg::entry_t              right_entry,
	output spq_pkg::entry_t                   entry,
	output logic                              keep_out
);

	localparam int CNT_W = $clog2(DEPTH+1);

	spq_pkg::entry_t entry_q;
	logic            valid;

	// Slot holds a live entry when it lies below the fill count
	assign valid = CNT_W'(INDEX) < count;

	// Live entry with priority lower or equal stays in place on a push
	assign keep_out = valid &&
		($signed(entry_q.prio) <= $signed(ctrl.new_entry.prio));

	// Push: first non-kept slot takes the new entry, later ones shift right.
	// Pop: every slot takes its right neighbor.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (!keep_out) begin
				entry_q <= left_keep ? ctrl.new_entry : left_entry;
			end
		end else if (ctrl.pop) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

FILE: src/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded min-first priority queue built from a chain of shifting cells.
// ----------------------------------------------------------------------------
// Takes one request per clock (push, pop, peek head, clear) and returns one
// result per request, presented in the cycle after acceptance; the request side
// stays ready while the result register is empty or being drained, so a
// request can be accepted every cycle. Entries sit in a row of DEPTH cells in
// ascending priority order; a push compares the new priority against all
// cells in parallel and each cell decides from its left neighbor whether to
// keep, take the new entry or shift right, while a pop shifts every cell
// left. Equal priorities leave in arrival order. Pop or peek on an empty
// queue reports status empty, a push to a full queue is dropped and reports
// status full. The count field shows the entry count modulo 32.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	spq_req_if.sink    req,
	spq_res_if.source  res
);

	localparam int CNT_W = $clog2(DEPTH+1);

	spq_pkg::req_t      req_kind;
	spq_pkg::cell_ctrl_t ctrl;
	spq_pkg::entry_t    cell_entry [DEPTH];
	logic [DEPTH-1:0]   cell_keep;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic [CNT_W+spq_pkg::COUNT_OUT_W-1:0] count_ext;
	logic               accept;
	logic               empty;
	logic               full;
	logic               head_out;

	logic                                res_valid_q;
	logic [spq_pkg::DATA_W-1:0]          res_data_q;
	logic [spq_pkg::PRIO_W-1:0]          res_prio_q;
	spq_pkg::status_t                    res_status_q;
	spq_pkg::status_t                    status_d;
	logic [spq_pkg::COUNT_OUT_W-1:0]     res_count_q;
	logic                                res_empty_q;

	// Handshake
	assign req.ready = !res_valid_q || res.ready;
	assign accept    = req.valid && req.ready;
	assign req_kind  = spq_pkg::req_t'(req.req_type);

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));

	// Cell control
	always_comb begin
		ctrl.push           = accept && (req_kind == spq_pkg::REQ_PUSH) && !full;
		ctrl.pop            = accept && (req_kind == spq_pkg::REQ_POP) && !empty;
		ctrl.new_entry.data = req.new_data;
		ctrl.new_entry.prio = req.new_priority;
	end

	// Cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_cell #(
			.DEPTH (DEPTH),
			.INDEX (i)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.count       (count_q),
			.left_entry  (cell_entry[(i == 0) ? 0 : i-1]),
			.left_keep   ((i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i-1]),
			.right_entry (cell_entry[(i == DEPTH-1) ? i : i+1]),
			.entry       (cell_entry[i]),
			.keep_out    (cell_keep[i])
		);
	end

	// Next count and result status
	always_comb begin
		count_d  = count_q;
		status_d = spq_pkg::ST_OK;
		head_out = 1'b0;
		case (req_kind)
			spq_pkg::REQ_PUSH: begin
				if (full) begin
					status_d = spq_pkg::ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			spq_pkg::REQ_POP: begin
				if (empty) begin
					status_d = spq_pkg::ST_EMPTY;
				end else begin
					count_d  = count_q - CNT_W'(1);
					head_out = 1'b1;
				end
			end
			spq_pkg::REQ_PEEK: begin
				if (empty) begin
					status_d = spq_pkg::ST_EMPTY;
				end else begin
					head_out = 1'b1;
				end
			end
			spq_pkg::REQ_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	assign count_ext = (CNT_W+spq_pkg::COUNT_OUT_W)'(count_d);

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_data_q   <= head_out ? cell_entry[0].data : '0;
			res_prio_q   <= head_out ? cell_entry[0].prio : '0;
			res_status_q <= status_d;
			res_count_q  <= count_ext[spq_pkg::COUNT_OUT_W-1:0];
			res_empty_q  <= (count_d == '0);
		end
	end

	assign res.valid        = res_valid_q;
	assign res.out_data     = res_data_q;
	assign res.out_priority = res_prio_q;
	assign res.status       = res_status_q;
	assign res.count        = res_count_q;
	assign res.empty_res    = res_empty_q;

	// Checks
	`SPQ_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))
	`SPQ_ASSERT_NEXT(a_full_flag, accept && (req_kind == spq_pkg::REQ_PUSH) && full,
		(res_status_q == spq_pkg::ST_FULL) && (count_q == $past(count_q)))
	`SPQ_ASSERT_NEXT(a_pop_dec, ctrl.pop, count_q == $past(count_q) - CNT_W'(1))
	`SPQ_ASSERT_NEXT(a_empty_head, accept && empty && (req_kind == spq_pkg::REQ_POP),
		(res_status_q == spq_pkg::ST_EMPTY) && (res_data_q == '0) && res_empty_q)

endmodule

`default_nettype wire

FILE: tb/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the min-first sorted priority queue.
// ----------------------------------------------------------------------------
// A directed table covers the empty, full, tie and extreme-priority cases.
// Random fill, drain and mixed bursts follow. Every accepted request runs
// through a local sorted-array predictor. Each result is checked field by
// field against the oldest pending expectation, under varying source and
// sink stalls.
// ----------------------------------------------------------------------------

module tb_sorted_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH = spq_pkg::DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_PER_PHASE = 450;
	localparam logic signed [31:0] S_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] S_MIN = 32'sh80000000;

	typedef struct packed {
		logic signed [31:0] data;
		logic signed [31:0] prio;
		spq_pkg::status_t   st;
		logic [4:0]         cnt;
		logic               empty;
	} result_t;

	typedef struct {
		spq_pkg::req_t      op;
		logic signed [31:0] data;
		logic signed [31:0] prio;
		int                 times;
		bit                 typed;
		result_t            want;
	} stim_row_t;

	localparam result_t R_NONE = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	spq_req_if req_ch ();
	spq_res_if res_ch ();

	sorted_priority_queue uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state: sorted entries, smallest priority first
	logic signed [31:0] held_data [QDEPTH];
	logic signed [31:0] held_prio [QDEPTH];
	int held = 0;

	result_t pending_results[$];
	result_t cur_want;
	bit cur_typed = 1'b0;

	int send_idle_pct = 20;
	int recv_idle_pct = 62;
	int mismatches = 0;
	int results_seen = 0;
	int cycles = 0;
	int n_push = 0, n_pop = 0, n_peek = 0, n_clear = 0;
	int n_full = 0, n_empty_err = 0, max_held = 0;

	// directed requests; typed rows carry an expected result read off the spec
	stim_row_t dir_rows[] = '{
		'{spq_pkg::REQ_POP, 0, 0, 1, 1,
			'{32'sd0, 32'sd0, spq_pkg::ST_EMPTY, 5'd0, 1'b1}},
		'{spq_pkg::REQ_PEEK, 0, 0, 1, 1,
			'{32'sd0, 32'sd0, spq_pkg::ST_EMPTY, 5'd0, 1'b1}},
		'{spq_pkg::REQ_CLEAR, 0, 0, 1, 1,
			'{32'sd0, 32'sd0, spq_pkg::ST_OK, 5'd0, 1'b1}},
		'{spq_pkg::REQ_PUSH, S_MAX, S_MAX, 1, 1,
			'{32'sd0, 32'sd0, spq_pkg::ST_OK, 5'd1, 1'b0}},
		'{spq_pkg::REQ_PUSH, S_MIN, S_MIN, 1, 1,
			'{32'sd0, 32'sd0, spq_pkg::ST_OK, 5'd2, 1'b0}},
		'{spq_pkg::REQ_PEEK, 0, 0, 1, 1,
			'{S_MIN, S_MIN, spq_pkg::ST_OK, 5'd2, 1'b0}},
		'{spq_pkg::REQ_PUSH, 0, 0, 1, 0, R_NONE},
		'{spq_pkg::REQ_PUSH, -1, -1, 1, 0, R_NONE},
		'{spq_pkg::REQ_PUSH, 5, 0, 1, 0, R_NONE},
		'{spq_pkg::REQ_POP, 0, 0, 1, 1,
			'{S_MIN, S_MIN, spq_pkg::ST_OK, 5'd4, 1'b0}},
		'{spq_pkg::REQ_POP, 0, 0, 1, 0, R_NONE},
		'{spq_pkg::REQ_POP, 0, 0, 1, 0, R_NONE},
		'{spq_pkg::REQ_POP, 0, 0, 1, 0, R_NONE},
		// fill up with equal priorities, data counts up per repeat
		'{spq_pkg::REQ_PUSH, 100, 3, 15, 0, R_NONE},
		'{spq_pkg::REQ_PUSH, -7, S_MIN, 1, 1,
			'{32'sd0, 32'sd0, spq_pkg::ST_FULL, 5'd16, 1'b0}},
		'{spq_pkg::REQ_PEEK, 0, 0, 1, 0, R_NONE},
		'{spq_pkg::REQ_POP, 0, 0, 1, 0, R_NONE},
		'{spq_pkg::REQ_PUSH, 55, 3, 1, 0, R_NONE},
		'{spq_pkg::REQ_PUSH, 9, -9, 1, 1,
			'{32'sd0, 32'sd0, spq_pkg::ST_FULL, 5'd16, 1'b0}},
		'{spq_pkg::REQ_CLEAR, 0, 0, 1, 1,
			'{32'sd0, 32'sd0, spq_pkg::ST_OK, 5'd0, 1'b1}},
		'{spq_pkg::REQ_PEEK, 0, 0, 1, 1,
			'{32'sd0, 32'sd0, spq_pkg::ST_EMPTY, 5'd0, 1'b1}},
		'{spq_pkg::REQ_PUSH, 1, S_MAX, 1, 0, R_NONE},
		'{spq_pkg::REQ_PUSH, 2, S_MAX, 1, 0, R_NONE},
		'{spq_pkg::REQ_POP, 0, 0, 1, 0, R_NONE},
		'{spq_pkg::REQ_CLEAR, 0, 0, 1, 1,
			'{32'sd0, 32'sd0, spq_pkg::ST_OK, 5'd0, 1'b1}}
	};

	// sorted-array queue step: updates the held entries, returns the result
	function automatic result_t step_queue(spq_pkg::req_t op, logic signed [31:0] d,
			logic signed [31:0] p);
		result_t r;
		int pos;
		r = '0;
		r.st = spq_pkg::ST_OK;
		case (op)
			spq_pkg::REQ_PUSH: begin
				n_push++;
				if (held >= QDEPTH) begin
					r.st = spq_pkg::ST_FULL;
					n_full++;
				end else begin
					// insert after every entry with lower or equal priority
					pos = 0;
					while (pos < held && held_prio[pos] <= p)
						pos++;
					for (int i = held; i > pos; i--) begin
						held_data[i] = held_data[i-1];
						held_prio[i] = held_prio[i-1];
					end
					held_data[pos] = d;
					held_prio[pos] = p;
					held++;
				end
			end
			spq_pkg::REQ_POP, spq_pkg::REQ_PEEK: begin
				if (op == spq_pkg::REQ_POP)
					n_pop++;
				else
					n_peek++;
				if (held == 0) begin
					r.st = spq_pkg::ST_EMPTY;
					n_empty_err++;
				end else begin
					r.data = held_data[0];
					r.prio = held_prio[0];
					if (op == spq_pkg::REQ_POP) begin
						for (int i = 1; i < held; i++) begin
							held_data[i-1] = held_data[i];
							held_prio[i-1] = held_prio[i];
						end
						held--;
					end
				end
			end
			default: begin
				n_clear++;
				held = 0;
			end
		endcase
		if (held > max_held)
			max_held = held;
		r.cnt = 5'(held);
		r.empty = (held == 0);
		return r;
	endfunction

	// one line per mismatch
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("MISMATCH result %0d %s: got %0h want %0h", results_seen, what,
			got, want);
	endtask

	task automatic check_result();
		result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("unexpected result, status", 32'(res_ch.status), 32'd0);
		end else begin
			want = pending_results.pop_front();
			if (res_ch.out_data !== want.data)
				report_mismatch("out_data", res_ch.out_data, want.data);
			if (res_ch.out_priority !== want.prio)
				report_mismatch("out_priority", res_ch.out_priority, want.prio);
			if (res_ch.status !== want.st)
				report_mismatch("status", 32'(res_ch.status), 32'(want.st));
			if (res_ch.count !== want.cnt)
				report_mismatch("count", 32'(res_ch.count), 32'(want.cnt));
			if (res_ch.empty_res !== want.empty)
				report_mismatch("empty_res", 32'(res_ch.empty_res), 32'(want.empty));
		end
		results_seen++;
	endtask

	// monitor: check results, predict accepted requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				check_result();
			if (req_ch.valid && req_ch.ready) begin
				if (cur_typed) begin
					void'(step_queue(spq_pkg::req_t'(req_ch.req_type), req_ch.new_data,
						req_ch.new_priority));
					pending_results.push_back(cur_want);
				end else begin
					pending_results.push_back(step_queue(spq_pkg::req_t'(req_ch.req_type),
						req_ch.new_data, req_ch.new_priority));
				end
			end
		end
	end

	// result sink stalls
	always @(negedge clk) begin
		if (arst_n)
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_results.size());
			$display("tb_sorted_priority_queue NOT OK");
			$finish;
		end
	end

	// drive one request at the falling edge, hold until accepted
	task automatic send_request(spq_pkg::req_t op, logic signed [31:0] d,
			logic signed [31:0] p, bit typed, result_t want);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.req_type = op;
		req_ch.new_data = d;
		req_ch.new_priority = p;
		cur_typed = typed;
		cur_want = want;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	function automatic logic signed [31:0] pick_priority();
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			2, 3, 4: return $urandom;
			default: return $signed(32'($urandom_range(8))) - 32'sd4;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_data();
		case ($urandom_range(7))
			0: return S_MAX;
			1: return S_MIN;
			2: return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	// bursts lean toward filling, draining or a mix
	function automatic spq_pkg::req_t pick_op(int regime);
		int r;
		r = $urandom_range(99);
		case (regime)
			0:
				return (r < 75) ? spq_pkg::REQ_PUSH : (r < 90) ? spq_pkg::REQ_POP :
					(r < 97) ? spq_pkg::REQ_PEEK : spq_pkg::REQ_CLEAR;
			1:
				return (r < 25) ? spq_pkg::REQ_PUSH : (r < 85) ? spq_pkg::REQ_POP :
					(r < 98) ? spq_pkg::REQ_PEEK : spq_pkg::REQ_CLEAR;
			default:
				return (r < 45) ? spq_pkg::REQ_PUSH : (r < 80) ? spq_pkg::REQ_POP :
					(r < 97) ? spq_pkg::REQ_PEEK : spq_pkg::REQ_CLEAR;
		endcase
	endfunction

	// stimulus and end of run
	initial begin
		int regime;
		spq_pkg::req_t op;
		req_ch.valid = 1'b0;
		req_ch.req_type = spq_pkg::REQ_PUSH;
		req_ch.new_data = '0;
		req_ch.new_priority = '0;
		res_ch.ready = 1'b0;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (dir_rows[k]) begin
			for (int n = 0; n < dir_rows[k].times; n++)
				send_request(dir_rows[k].op, dir_rows[k].data + n, dir_rows[k].prio,
					dir_rows[k].typed, dir_rows[k].want);
		end

		// random bursts in three stall settings
		regime = 0;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 62 : 0;
			recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 20 : 0;
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				if (n % 40 == 0)
					regime = $urandom_range(2);
				op = pick_op(regime);
				if (op == spq_pkg::REQ_PUSH)
					send_request(op, pick_data(), pick_priority(), 1'b0, R_NONE);
				else
					send_request(op, $urandom, $urandom, 1'b0, R_NONE);
			end
		end

		@(negedge clk);
		req_ch.valid = 1'b0;

		// drain the pending expectations, then report
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("requests: %0d push, %0d pop, %0d peek, %0d clear; %0d results checked",
			n_push, n_pop, n_peek, n_clear, results_seen);
		$display("full pushes %0d, empty pops/peeks %0d, deepest fill %0d, mismatches %0d",
			n_full, n_empty_err, max_held, mismatches);
		if (mismatches == 0)
			$display("tb_sorted_priority_queue OK");
		else
			$display("tb_sorted_priority_queue NOT OK");
		$finish;
	end

endmodule
